[hdl/running_prefix_average_assert.svh]
// Assertion macros for the running prefix average block.
`ifndef RUNNING_PREFIX_AVERAGE_ASSERT_SVH
`define RUNNING_PREFIX_AVERAGE_ASSERT_SVH

// Same-cycle implication, reset-gated.
`define RPA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, reset-gated.
`define RPA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/rpa_pkg.sv]
// Shared widths, constants and types of the running prefix average block.
`timescale 1ns / 1ps
`default_nettype none
package rpa_pkg;

	localparam int SAMPLE_W = 16;
	localparam int AVG_W    = 16;
	localparam int SUM_W    = 32;
	localparam int COUNT_W  = 16;
	// dividend 2*sum+count, divisor 2*count
	localparam int DVD_W    = SUM_W + 1;
	localparam int DVS_W    = COUNT_W + 1;
	localparam int STEP_W   = $clog2(AVG_W + 1);

	localparam int SAMPLE_BITS = 16;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
		(SAMPLE_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}} : SAMPLE_W'((1 << SAMPLE_BITS) - 1);
	localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(65535);

	typedef struct packed {
		logic               valid;
		logic               ovf;
		logic [SUM_W-1:0]   sum;
		logic [COUNT_W-1:0] count;
	} rpa_step_t;

	typedef struct packed {
		logic start;
		logic ack;
	} rpa_div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} rpa_div_stat_t;

endpackage
`default_nettype wire

[hdl/rpa_if.sv]
// Valid/ready channel interfaces for sample items and result items.
`timescale 1ns / 1ps
`default_nettype none
interface rpa_in_if;
	logic                          valid;
	logic                          ready;
	logic [rpa_pkg::SAMPLE_W-1:0]  sample;
	logic                          last_item;

	modport source (output valid, output sample, output last_item, input ready);
	modport sink   (input valid, input sample, input last_item, output ready);
endinterface

interface rpa_out_if;
	logic                       valid;
	logic                       ready;
	logic [rpa_pkg::AVG_W-1:0]  average;
	logic                       overflow;

	modport source (output valid, output average, output overflow, input ready);
	modport sink   (input valid, input average, input overflow, output ready);
endinterface
`default_nettype wire

[hdl/running_prefix_average.sv]
// Top level of the running prefix average: accumulator, serial divider, result register.
//
//   channel   dir   handshake        payload
//   samples   in    valid / ready    sample[15:0], last_item
//   results   out   valid / ready    average[15:0], overflow
//
// One item in flight: the accept edge registers the new sum and count, the next edge
// loads the divider, 16 divider steps follow (one quotient bit per cycle), then the
// result register takes the result. The next item can be taken the cycle after the
// previous result enters the output register. A result left waiting holds the following
// item in the divider, and that holds the input off. Reset (arst_n low) clears sum,
// count and all control.
`timescale 1ns / 1ps
`default_nettype none
`include "running_prefix_average_assert.svh"
module running_prefix_average (
	input  wire logic   clk,
	input  wire logic   arst_n,
	rpa_in_if.sink      samples,
	rpa_out_if.source   results
);

	rpa_pkg::rpa_step_t       step;
	rpa_pkg::rpa_div_req_t    req;
	rpa_pkg::rpa_div_stat_t   stat;
	logic [rpa_pkg::AVG_W-1:0] quotient;

	logic                      busy_q;
	logic                      ovf_q;
	logic                      zero_q;
	logic                      out_valid_q;
	logic [rpa_pkg::AVG_W-1:0] avg_q;
	logic                      out_ovf_q;

	logic                      accept;
	logic                      load;

	assign samples.ready = ~busy_q;
	assign accept        = samples.valid & ~busy_q;
	assign load          = stat.done & (~out_valid_q | results.ready);
	assign req           = '{start: step.valid, ack: load};

	rpa_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.sample    (samples.sample),
		.last_item (samples.last_item),
		.step      (step)
	);

	rpa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.sum      (step.sum),
		.count    (step.count),
		.stat     (stat),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (load) begin
				busy_q <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step.valid) begin
			ovf_q  <= step.ovf;
			zero_q <= (step.count == '0);
		end
		if (load) begin
			// empty count guard: the quotient is not used, mean reads as zero
			avg_q     <= zero_q ? '0 : quotient;
			out_ovf_q <= ovf_q;
		end
	end

	assign results.valid    = out_valid_q;
	assign results.average  = avg_q;
	assign results.overflow = out_ovf_q;

	`RPA_ASSERT_NEXT(a_accept_sets_busy, accept, busy_q && !samples.ready, "accept did not mark the block busy")
	`RPA_ASSERT_NOW(a_start_while_busy, step.valid, busy_q && !stat.busy, "divider start outside a busy item")
	`RPA_ASSERT_NOW(a_done_while_busy, stat.done, busy_q, "divider result with no item in flight")
	`RPA_ASSERT_NEXT(a_load_frees_input, load, !busy_q && out_valid_q && !stat.busy, "result load did not free the input")

endmodule
`default_nettype wire

[hdl/rpa_accum.sv]
// Running sum and item count, with count-full hold and end-of-sequence clear.
`timescale 1ns / 1ps
`default_nettype none
module rpa_accum (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire logic [rpa_pkg::SAMPLE_W-1:0]  sample,
	input  wire logic                          last_item,
	output rpa_pkg::rpa_step_t                 step
);

	logic [rpa_pkg::SUM_W-1:0]   sum_q;
	logic [rpa_pkg::COUNT_W-1:0] count_q;
	logic [rpa_pkg::SUM_W-1:0]   sum_s1;
	logic [rpa_pkg::COUNT_W-1:0] count_s1;
	logic                        valid_s1;
	logic                        ovf_s1;

	logic                        full;
	logic [rpa_pkg::SUM_W-1:0]   sum_nxt;
	logic [rpa_pkg::COUNT_W-1:0] count_nxt;

	always_comb begin
		full = (count_q >= rpa_pkg::MAX_COUNT);
		if (full) begin
			sum_nxt   = sum_q;
			count_nxt = count_q;
		end else begin
			sum_nxt   = sum_q + rpa_pkg::SUM_W'(sample & rpa_pkg::SAMPLE_MASK);
			count_nxt = count_q + rpa_pkg::COUNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				// a last item still reports the mean before the clear
				sum_q   <= last_item ? '0 : sum_nxt;
				count_q <= last_item ? '0 : count_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sum_s1   <= sum_nxt;
			count_s1 <= count_nxt;
			ovf_s1   <= full;
		end
	end

	assign step = '{valid: valid_s1, ovf: ovf_s1, sum: sum_s1, count: count_s1};

endmodule
`default_nettype wire

[hdl/rpa_div.sv]
// Bit-serial restoring divider: (2*sum+count) / (2*count), one quotient bit a cycle.
`timescale 1ns / 1ps
`default_nettype none
module rpa_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire rpa_pkg::rpa_div_req_t        req,
	input  wire logic [rpa_pkg::SUM_W-1:0]    sum,
	input  wire logic [rpa_pkg::COUNT_W-1:0]  count,
	output rpa_pkg::rpa_div_stat_t            stat,
	output logic [rpa_pkg::AVG_W-1:0]         quotient
);

	typedef enum logic [1:0] {IDLE, RUN, DONE} state_t;

	state_t                       state_q;
	logic [rpa_pkg::STEP_W-1:0]   steps_q;
	logic [rpa_pkg::DVS_W-1:0]    rem_q;
	logic [rpa_pkg::DVS_W-1:0]    dvs_q;
	logic [rpa_pkg::AVG_W-1:0]    quo_q;

	logic [rpa_pkg::DVD_W-1:0]    dividend;
	logic [rpa_pkg::DVS_W+1:0]    diff;
	logic                         ge;

	assign dividend = {sum, 1'b0} + rpa_pkg::DVD_W'(count);
	// mean never exceeds the sample range, so the upper dividend bits sit below the divisor
	assign diff = {1'b0, rem_q, quo_q[rpa_pkg::AVG_W-1]} - {2'b00, dvs_q};
	assign ge   = ~diff[rpa_pkg::DVS_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			steps_q <= '0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (req.start) begin
						state_q <= RUN;
						steps_q <= rpa_pkg::STEP_W'(rpa_pkg::AVG_W);
					end
				end
				RUN: begin
					steps_q <= steps_q - rpa_pkg::STEP_W'(1);
					if (steps_q == rpa_pkg::STEP_W'(1)) begin
						state_q <= DONE;
					end
				end
				DONE: begin
					if (req.ack) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == IDLE && req.start) begin
			rem_q <= dividend[rpa_pkg::DVD_W-1:rpa_pkg::AVG_W];
			quo_q <= dividend[rpa_pkg::AVG_W-1:0];
			dvs_q <= {count, 1'b0};
		end else if (state_q == RUN) begin
			rem_q <= ge ? diff[rpa_pkg::DVS_W-1:0] : {rem_q[rpa_pkg::DVS_W-2:0], quo_q[rpa_pkg::AVG_W-1]};
			quo_q <= {quo_q[rpa_pkg::AVG_W-2:0], ge};
		end
	end

	assign stat     = '{busy: (state_q != IDLE), done: (state_q == DONE)};
	assign quotient = quo_q;

endmodule
`default_nettype wire

[tb/sv/running_prefix_average_tb.sv]
// Testbench for running_prefix_average: directed table, then random sequences.
`timescale 1ns / 1ps
module running_prefix_average_tb;
	import rpa_pkg::*;

	typedef struct packed {
		logic [AVG_W-1:0] average;
		logic             overflow;
	} mean_exp_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                last_item;
		logic                pinned;
		logic [AVG_W-1:0]    average;
		logic                overflow;
	} probe_row_t;

	// pinned rows carry a hand-computed result; the rest go through the predictor
	localparam probe_row_t PROBE_ROWS [0:15] = '{
		'{16'h0000, 1'b1, 1'b1, 16'h0000, 1'b0},  // first item after reset
		'{16'hFFFF, 1'b1, 1'b1, 16'hFFFF, 1'b0},
		'{16'h0000, 1'b0, 1'b1, 16'h0000, 1'b0},
		'{16'h0001, 1'b1, 1'b1, 16'h0001, 1'b0},  // 0.5 rounds up
		'{16'h0001, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{16'h0002, 1'b1, 1'b1, 16'h0002, 1'b0},  // 1.5 rounds up
		'{16'hFFFF, 1'b0, 1'b1, 16'hFFFF, 1'b0},
		'{16'h0000, 1'b1, 1'b1, 16'h8000, 1'b0},
		'{16'h0005, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{16'h0005, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{16'h0006, 1'b1, 1'b0, 16'h0000, 1'b0},
		'{16'hAAAA, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{16'h5555, 1'b1, 1'b1, 16'h8000, 1'b0},
		'{16'h8000, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{16'h7FFF, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{16'h0001, 1'b1, 1'b0, 16'h0000, 1'b0}
	};

	logic clk;
	logic arst_n;

	rpa_in_if  in_ch ();
	rpa_out_if out_ch ();

	running_prefix_average dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (in_ch),
		.results (out_ch)
	);

	logic [SUM_W-1:0]   acc_sum;
	logic [COUNT_W-1:0] acc_count;
	mean_exp_t          pending_means [$];
	int                 errors;
	bit                 gaps_on;
	bit                 stall_on;
	bit                 long_hold;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#25_000_000;
		$display("running_prefix_average_tb: done, errors");
		$finish;
	end

	function automatic void predict_mean(input logic [SAMPLE_W-1:0] s, input logic l,
			output logic [AVG_W-1:0] avg, output logic ovf);
		logic [63:0] dividend;
		logic [63:0] divisor;
		ovf = (acc_count >= MAX_COUNT);
		if (!ovf) begin
			acc_sum   = acc_sum + SUM_W'(s & SAMPLE_MASK);
			acc_count = acc_count + 1'b1;
		end
		if (acc_count == '0) begin
			avg = '0;
		end else begin
			dividend = (64'(acc_sum) << 1) + 64'(acc_count);
			divisor  = 64'(acc_count) << 1;
			avg      = AVG_W'(dividend / divisor);
		end
		if (l) begin
			acc_sum   = '0;
			acc_count = '0;
		end
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: pick_sample = '0;
			1: pick_sample = '1;
			2: pick_sample = SAMPLE_W'($urandom_range(0, 15));
			default: pick_sample = SAMPLE_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// Leaves valid high on return; the caller either sends again in the same step or lowers it.
	task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic l, input logic pinned,
			input logic [AVG_W-1:0] pin_avg, input logic pin_ovf);
		mean_exp_t e;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.sample    <= s;
		in_ch.last_item <= l;
		do @(posedge clk); while (!in_ch.ready);
		predict_mean(s, l, e.average, e.overflow);
		if (pinned) begin
			e.average  = pin_avg;
			e.overflow = pin_ovf;
		end
		pending_means.push_back(e);
	endtask

	task automatic send_sequences(input int total);
		int sent;
		int seq_len;
		logic l;
		sent = 0;
		while (sent < total) begin
			seq_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			for (int k = 0; k < seq_len; k++) begin
				l = (k == seq_len - 1);
				// occasional broken sequence: early or missing end mark
				if ($urandom_range(0, 19) == 0)
					l = ~l;
				send_sample(pick_sample(), l, 1'b0, '0, 1'b0);
				sent++;
			end
		end
	endtask

	initial begin
		out_ch.ready <= 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_ch.ready <= 1'b0;
				repeat (400) @(posedge clk);
				long_hold = 1'b0;
			end else if (stall_on && $urandom_range(0, 4) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : result_check
		mean_exp_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_means.size() == 0) begin
				$error("unexpected item: average %0d overflow %0d", out_ch.average,
					out_ch.overflow);
				errors++;
			end else begin
				e = pending_means.pop_front();
				if (out_ch.average !== e.average) begin
					$error("average: expected %0d, got %0d", e.average, out_ch.average);
					errors++;
				end
				if (out_ch.overflow !== e.overflow) begin
					$error("overflow: expected %0d, got %0d", e.overflow, out_ch.overflow);
					errors++;
				end
			end
		end
	end

	initial begin : stimulus
		acc_sum   = '0;
		acc_count = '0;
		errors    = 0;
		gaps_on   = 1'b1;
		stall_on  = 1'b1;
		long_hold = 1'b0;
		arst_n    = 1'b0;
		in_ch.valid     <= 1'b0;
		in_ch.sample    <= '0;
		in_ch.last_item <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (PROBE_ROWS[i])
			send_sample(PROBE_ROWS[i].sample, PROBE_ROWS[i].last_item, PROBE_ROWS[i].pinned,
				PROBE_ROWS[i].average, PROBE_ROWS[i].overflow);

		for (int phase = 0; phase < 8; phase++) begin
			gaps_on  = ($urandom_range(0, 3) != 0);
			stall_on = ($urandom_range(0, 3) != 0);
			send_sequences(40);
			if (phase == 2) begin
				// receiver holds off while items keep coming
				long_hold = 1'b1;
				gaps_on   = 1'b0;
				repeat (12)
					send_sample(pick_sample(), 1'b0, 1'b0, '0, 1'b0);
			end
			if (phase == 5) begin
				in_ch.valid <= 1'b0;
				while (pending_means.size() != 0) @(posedge clk);
			end
		end

		gaps_on  = 1'b0;
		stall_on = 1'b0;
		send_sequences(60);
		in_ch.valid <= 1'b0;

		while (pending_means.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("running_prefix_average_tb: done, clean");
		else
			$display("running_prefix_average_tb: done, errors");
		$finish;
	end
endmodule
